// ===== sv/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the source token scanner
// Character classes, token kind codes, error codes, the keyword list and the
// beat formats passed between the front queue, the lexer and the token queue.
// ----------------------------------------------------------------------------
package sts_pkg;

   // Keyword buffer depth; identifiers longer than this are never keywords
   localparam int KW_MAX_LEN    = 8;
   localparam int KW_IDX_W      = $clog2(KW_MAX_LEN);
   localparam int KW_COUNT      = 24;
   // Keyword text is stored left-aligned in 8 bytes (longest keyword is 8)
   localparam int KW_TEXT_CHARS = 8;

   // Queue depths, powers of two so pointers wrap on their own
   localparam int IN_DEPTH  = 2;
   localparam int IN_PTR_W  = $clog2(IN_DEPTH);
   localparam int IN_CNT_W  = $clog2(IN_DEPTH + 1);
   localparam int TOK_DEPTH = 4;
   localparam int TOK_PTR_W = $clog2(TOK_DEPTH);
   localparam int TOK_CNT_W = $clog2(TOK_DEPTH + 1);

   localparam logic [15:0] FIRST_LINE_RESET = 16'd1;
   localparam logic [15:0] SAT16            = 16'hFFFF;

   // Token kinds (punctuators 0..14 are their class index)
   localparam logic [5:0] KIND_BANG       = 6'd15;
   localparam logic [5:0] KIND_BANG_EQUAL = 6'd16;
   localparam logic [5:0] KIND_EQUAL      = 6'd17;
   localparam logic [5:0] KIND_EQUAL_EQ   = 6'd18;
   localparam logic [5:0] KIND_GREATER    = 6'd19;
   localparam logic [5:0] KIND_GREATER_EQ = 6'd20;
   localparam logic [5:0] KIND_LESS       = 6'd21;
   localparam logic [5:0] KIND_LESS_EQ    = 6'd22;
   localparam logic [5:0] KIND_AND_AND    = 6'd23;
   localparam logic [5:0] KIND_OR_OR      = 6'd24;
   localparam logic [5:0] KIND_NUMBER     = 6'd25;
   localparam logic [5:0] KIND_IDENT      = 6'd26;
   localparam logic [5:0] KIND_STRING     = 6'd27;
   localparam logic [5:0] KIND_KW_BASE    = 6'd28;
   localparam logic [5:0] KIND_ERROR      = 6'd52;
   localparam logic [5:0] KIND_END        = 6'd53;

   // Error codes
   localparam logic [1:0] ERR_NONE         = 2'd0;
   localparam logic [1:0] ERR_UNEXPECTED   = 2'd1;
   localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

   // Character classes assigned by the front end
   typedef enum logic [3:0] {
      CLS_PUNCT,
      CLS_SPACE,
      CLS_NEWLINE,
      CLS_HASH,
      CLS_BANG,
      CLS_EQUAL,
      CLS_GREATER,
      CLS_LESS,
      CLS_AMP,
      CLS_PIPE,
      CLS_QUOTE,
      CLS_DIGIT,
      CLS_ALPHA,
      CLS_OTHER
   } char_class_type;

   // Classified source beat
   typedef struct packed {
      logic [7:0]     char_byte;
      logic           end_of_input;
      char_class_type cls;
      logic [3:0]     punct_idx;
   } front_item_type;

   // One result beat
   typedef struct packed {
      logic [5:0]  kind;
      logic [31:0] start;
      logic [15:0] length;
      logic [15:0] line;
      logic [1:0]  err;
      logic        last;
   } token_type;

   typedef struct packed {
      logic      valid;
      token_type tok;
   } tok_slot_type;

   // Keyword text, first character in the top byte, zero padded
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      {"class", 24'h0}, {"var", 40'h0},  {"if", 48'h0},    {"else", 32'h0},
      {"while", 24'h0}, {"for", 40'h0},  {"new", 40'h0},   {"init", 32'h0},
      {"this", 32'h0},  {"true", 32'h0}, {"false", 24'h0}, {"nil", 40'h0},
      {"return", 16'h0}, {"break", 24'h0}, {"continue"},   {"print", 24'h0},
      {"fun", 40'h0},   {"super", 24'h0}, {"int", 40'h0},  {"string", 16'h0},
      {"bool", 32'h0},  {"float", 24'h0}, {"double", 16'h0}, {"void", 32'h0}
   };

   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd5, 4'd3, 4'd2, 4'd4, 4'd5, 4'd3, 4'd3, 4'd4,
      4'd4, 4'd4, 4'd5, 4'd3, 4'd6, 4'd5, 4'd8, 4'd5,
      4'd3, 4'd5, 4'd3, 4'd6, 4'd4, 4'd5, 4'd6, 4'd4
   };

endpackage

// ===== sv/source_token_scanner.sv =====
// ----------------------------------------------------------------------------
// source_token_scanner: streaming lexer, one source byte per beat
// Accepts one byte per cycle while req_full is low and emits tokens (kind,
// start offset, length, line, error code, last-of-run flag) through a token queue.
// ----------------------------------------------------------------------------
// Push one byte (or an end-of-input beat) per cycle while req_full is low.
// Each beat yields zero, one or two tokens; the final token of a beat carries
// rsp_last_of_run. The lexer takes one beat per cycle whenever the four-entry
// token queue has room for two tokens, so input runs at one byte per cycle as
// long as tokens are popped as fast as they are made; the single token read
// port (one token per cycle) sets the sustained rate when beats produce two
// tokens. A pushed byte is registered in the front queue; the lexer takes it
// when the token queue has room and writes its tokens there. Reset needs
// no clearing pass. Write csr_wr_data with csr_wr_en only while the block is
// idle; it sets the first line number and reloads the line counter at once.
module source_token_scanner
   import sts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_input,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [5:0]  rsp_token_kind,
   output logic [31:0] rsp_start_offset,
   output logic [15:0] rsp_token_length,
   output logic [15:0] rsp_line_number,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last_of_run
);

   logic           item_valid;
   front_item_type item;
   logic           item_take;
   logic           fifo_room;
   tok_slot_type   slot_a;
   tok_slot_type   slot_b;
   token_type      head;

   sts_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_char_byte    (req_char_byte),
      .req_end_of_input (req_end_of_input),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take)
   );

   sts_lexer u_lexer (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item        (item),
      .item_take   (item_take),
      .fifo_room   (fifo_room),
      .slot_a      (slot_a),
      .slot_b      (slot_b)
   );

   sts_tok_fifo u_tok_fifo (
      .clock     (clock),
      .reset     (reset),
      .slot_a    (slot_a),
      .slot_b    (slot_b),
      .room      (fifo_room),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .head      (head)
   );

   // Split the head token onto the result ports
   assign rsp_token_kind   = head.kind;
   assign rsp_start_offset = head.start;
   assign rsp_token_length = head.length;
   assign rsp_line_number  = head.line;
   assign rsp_error_code   = head.err;
   assign rsp_last_of_run  = head.last;

endmodule

// ===== sv/sts_front.sv =====
// ----------------------------------------------------------------------------
// sts_front: input side of the source token scanner
// Classifies each accepted source byte and holds it in a short queue until
// the lexer takes it.
// ----------------------------------------------------------------------------
module sts_front
   import sts_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_push,
   output logic           req_full,
   input  logic [7:0]     req_char_byte,
   input  logic           req_end_of_input,
   output logic           item_valid,
   output front_item_type item,
   input  logic           item_take
);

   front_item_type        q_ff [IN_DEPTH];
   logic [IN_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IN_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [IN_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                  push;
   logic                  pop;
   char_class_type        cls;
   logic [3:0]            punct_idx;

   // Decode the byte into its class
   always_comb begin
      cls       = CLS_OTHER;
      punct_idx = 4'd0;
      unique case (req_char_byte) inside
         8'h28: begin cls = CLS_PUNCT; punct_idx = 4'd0;  end  // (
         8'h29: begin cls = CLS_PUNCT; punct_idx = 4'd1;  end  // )
         8'h7B: begin cls = CLS_PUNCT; punct_idx = 4'd2;  end  // {
         8'h7D: begin cls = CLS_PUNCT; punct_idx = 4'd3;  end  // }
         8'h5B: begin cls = CLS_PUNCT; punct_idx = 4'd4;  end  // [
         8'h5D: begin cls = CLS_PUNCT; punct_idx = 4'd5;  end  // ]
         8'h2C: begin cls = CLS_PUNCT; punct_idx = 4'd6;  end  // ,
         8'h2E: begin cls = CLS_PUNCT; punct_idx = 4'd7;  end  // .
         8'h3B: begin cls = CLS_PUNCT; punct_idx = 4'd8;  end  // ;
         8'h3A: begin cls = CLS_PUNCT; punct_idx = 4'd9;  end  // :
         8'h2D: begin cls = CLS_PUNCT; punct_idx = 4'd10; end  // -
         8'h2B: begin cls = CLS_PUNCT; punct_idx = 4'd11; end  // +
         8'h2F: begin cls = CLS_PUNCT; punct_idx = 4'd12; end  // /
         8'h2A: begin cls = CLS_PUNCT; punct_idx = 4'd13; end  // *
         8'h25: begin cls = CLS_PUNCT; punct_idx = 4'd14; end  // %
         8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D: cls = CLS_SPACE;
         8'h0A: cls = CLS_NEWLINE;
         8'h23: cls = CLS_HASH;
         8'h21: cls = CLS_BANG;
         8'h3D: cls = CLS_EQUAL;
         8'h3E: cls = CLS_GREATER;
         8'h3C: cls = CLS_LESS;
         8'h26: cls = CLS_AMP;
         8'h7C: cls = CLS_PIPE;
         8'h22: cls = CLS_QUOTE;
         [8'h30:8'h39]: cls = CLS_DIGIT;
         [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F: cls = CLS_ALPHA;
         default: cls = CLS_OTHER;
      endcase
   end

   // Queue control
   always_comb begin
      req_full   = (cnt_ff == IN_CNT_W'(IN_DEPTH));
      push       = req_push && !req_full;
      item_valid = (cnt_ff != '0);
      pop        = item_take && item_valid;
      wr_ptr_in  = push ? wr_ptr_ff + IN_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = pop  ? rd_ptr_ff + IN_PTR_W'(1) : rd_ptr_ff;
      cnt_in     = cnt_ff + IN_CNT_W'(push) - IN_CNT_W'(pop);
      item       = q_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the classified beat
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{char_byte:    req_char_byte,
                              end_of_input: req_end_of_input,
                              cls:          cls,
                              punct_idx:    punct_idx};
      end
   end

endmodule

// ===== sv/sts_lexer.sv =====
// ----------------------------------------------------------------------------
// sts_lexer: token engine of the source token scanner
// Runs the scan state machine over classified beats, tracks offset, line and
// the pending token, matches keywords and hands up to two tokens per beat to
// the token queue.
// ----------------------------------------------------------------------------
module sts_lexer
   import sts_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_wr_en,
   input  logic [15:0]    csr_wr_data,
   input  logic           item_valid,
   input  front_item_type item,
   output logic           item_take,
   input  logic           fifo_room,
   output tok_slot_type   slot_a,
   output tok_slot_type   slot_b
);

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_BANG,
      MODE_EQ,
      MODE_GT,
      MODE_LT,
      MODE_AMP,
      MODE_PIPE,
      MODE_NUM,
      MODE_IDENT,
      MODE_STR
   } mode_type;

   mode_type      mode_ff, mode_in;
   logic [31:0]   offset_ff, offset_in;
   logic [15:0]   line_ff, line_in;
   logic [15:0]   first_line_ff, first_line_in;
   logic [15:0]   pend_len_ff, pend_len_in;
   logic [31:0]   pend_start_ff, pend_start_in;
   logic [7:0]    kw_buf_ff [KW_MAX_LEN];

   logic                kw_we;
   logic [KW_IDX_W-1:0] kw_addr;
   logic [15:0]         line_up;
   logic [15:0]         len_up;
   logic [5:0]          ident_kind;
   logic [5:0]          pair_kind;
   logic                second_hit;
   tok_slot_type        flush_slot;
   tok_slot_type        st_slot;
   mode_type            st_mode;
   logic                restart;
   tok_slot_type        a_raw, b_raw;

   // Saturating increments
   always_comb begin
      line_up = (line_ff == SAT16) ? line_ff : line_ff + 16'd1;
      len_up  = (pend_len_ff == SAT16) ? pend_len_ff : pend_len_ff + 16'd1;
   end

   // Match the buffered identifier against the keyword list
   always_comb begin
      logic kw_hit;
      ident_kind = KIND_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         kw_hit = (pend_len_ff == 16'(KW_LEN[k]));
         for (int i = 0; i < KW_TEXT_CHARS; i++) begin
            if (i < int'(KW_LEN[k]) && kw_buf_ff[i] != KW_TEXT[k][63-8*i -: 8]) begin
               kw_hit = 1'b0;
            end
         end
         if (kw_hit) begin
            ident_kind = 6'(KIND_KW_BASE + k);
         end
      end
   end

   // Decode the pending token: flushed form and two-character form
   always_comb begin
      flush_slot          = '0;
      flush_slot.valid    = 1'b1;
      flush_slot.tok.start  = pend_start_ff;
      flush_slot.tok.length = 16'd1;
      flush_slot.tok.line   = line_ff;
      flush_slot.tok.err    = ERR_NONE;
      pair_kind           = KIND_BANG_EQUAL;
      second_hit          = (item.cls == CLS_EQUAL);
      unique case (mode_ff)
         MODE_BANG: flush_slot.tok.kind = KIND_BANG;
         MODE_EQ: begin
            flush_slot.tok.kind = KIND_EQUAL;
            pair_kind           = KIND_EQUAL_EQ;
         end
         MODE_GT: begin
            flush_slot.tok.kind = KIND_GREATER;
            pair_kind           = KIND_GREATER_EQ;
         end
         MODE_LT: begin
            flush_slot.tok.kind = KIND_LESS;
            pair_kind           = KIND_LESS_EQ;
         end
         MODE_AMP: begin
            flush_slot.tok.kind = KIND_BANG;
            pair_kind           = KIND_AND_AND;
            second_hit          = (item.cls == CLS_AMP);
         end
         MODE_PIPE: begin
            flush_slot.tok.kind = KIND_BANG;
            pair_kind           = KIND_OR_OR;
            second_hit          = (item.cls == CLS_PIPE);
         end
         MODE_NUM: begin
            flush_slot.tok.kind   = KIND_NUMBER;
            flush_slot.tok.length = pend_len_ff;
         end
         MODE_IDENT: begin
            flush_slot.tok.kind   = ident_kind;
            flush_slot.tok.length = pend_len_ff;
         end
         MODE_STR: begin
            flush_slot.tok.kind   = KIND_ERROR;
            flush_slot.tok.length = pend_len_ff;
            flush_slot.tok.err    = ERR_UNTERMINATED;
         end
         default: flush_slot.valid = 1'b0;
      endcase
   end

   // Decode the start of a new token from the current beat
   always_comb begin
      st_slot             = '0;
      st_slot.valid       = (item.cls == CLS_PUNCT) || (item.cls == CLS_OTHER);
      st_slot.tok.kind    = (item.cls == CLS_PUNCT) ? {2'b00, item.punct_idx} : KIND_ERROR;
      st_slot.tok.start   = offset_ff;
      st_slot.tok.length  = 16'd1;
      st_slot.tok.line    = line_ff;
      st_slot.tok.err     = (item.cls == CLS_OTHER) ? ERR_UNEXPECTED : ERR_NONE;
      unique case (item.cls)
         CLS_BANG:    st_mode = MODE_BANG;
         CLS_EQUAL:   st_mode = MODE_EQ;
         CLS_GREATER: st_mode = MODE_GT;
         CLS_LESS:    st_mode = MODE_LT;
         CLS_AMP:     st_mode = MODE_AMP;
         CLS_PIPE:    st_mode = MODE_PIPE;
         CLS_QUOTE:   st_mode = MODE_STR;
         CLS_DIGIT:   st_mode = MODE_NUM;
         CLS_ALPHA:   st_mode = MODE_IDENT;
         default:     st_mode = MODE_IDLE;
      endcase
   end

   // Advance the scan state for one taken beat
   always_comb begin
      mode_in       = mode_ff;
      offset_in     = offset_ff;
      line_in       = line_ff;
      first_line_in = first_line_ff;
      pend_len_in   = pend_len_ff;
      pend_start_in = pend_start_ff;
      kw_we         = 1'b0;
      kw_addr       = '0;
      restart       = 1'b0;
      a_raw         = '0;
      b_raw         = '0;
      item_take     = item_valid && fifo_room;

      if (item_take) begin
         if (item.end_of_input) begin
            // Flush the pending token, then close the stream
            a_raw            = flush_slot;
            b_raw.valid      = 1'b1;
            b_raw.tok.kind   = KIND_END;
            b_raw.tok.start  = offset_ff;
            b_raw.tok.length = 16'd0;
            b_raw.tok.line   = line_ff;
            b_raw.tok.err    = ERR_NONE;
            mode_in          = MODE_IDLE;
            offset_in        = 32'd0;
            line_in          = first_line_ff;
         end else begin
            offset_in = offset_ff + 32'd1;
            unique case (mode_ff) inside
               MODE_BANG, MODE_EQ, MODE_GT, MODE_LT, MODE_AMP, MODE_PIPE: begin
                  if (second_hit) begin
                     a_raw            = flush_slot;
                     a_raw.tok.kind   = pair_kind;
                     a_raw.tok.length = 16'd2;
                     mode_in          = MODE_IDLE;
                  end else begin
                     restart = 1'b1;
                  end
               end
               MODE_NUM: begin
                  if (item.cls == CLS_DIGIT) begin
                     pend_len_in = len_up;
                  end else begin
                     restart = 1'b1;
                  end
               end
               MODE_IDENT: begin
                  if (item.cls == CLS_ALPHA || item.cls == CLS_DIGIT) begin
                     if (pend_len_ff < 16'(KW_MAX_LEN)) begin
                        kw_we   = 1'b1;
                        kw_addr = pend_len_ff[KW_IDX_W-1:0];
                     end
                     pend_len_in = len_up;
                  end else begin
                     restart = 1'b1;
                  end
               end
               MODE_STR: begin
                  if (item.cls == CLS_QUOTE) begin
                     a_raw          = flush_slot;
                     a_raw.tok.kind = KIND_STRING;
                     a_raw.tok.err  = ERR_NONE;
                     mode_in        = MODE_IDLE;
                  end else if (item.cls == CLS_NEWLINE) begin
                     // Count the line first; the error carries the new line
                     a_raw          = flush_slot;
                     a_raw.tok.line = line_up;
                     line_in        = line_up;
                     mode_in        = MODE_IDLE;
                  end else begin
                     pend_len_in = len_up;
                  end
               end
               default: restart = 1'b1;
            endcase

            // Push back the terminating byte as the start of the next token
            if (restart) begin
               a_raw   = flush_slot;
               b_raw   = st_slot;
               mode_in = st_mode;
               if (item.cls != CLS_PUNCT) begin
                  pend_start_in = offset_ff;
                  pend_len_in   = (item.cls == CLS_QUOTE) ? 16'd0 : 16'd1;
               end
               if (item.cls == CLS_NEWLINE) begin
                  line_in = line_up;
               end
               if (item.cls == CLS_ALPHA) begin
                  kw_we   = 1'b1;
                  kw_addr = '0;
               end
            end
         end
      end

      // Configuration load; the user must write only while the block is idle, and the block itself does not enforce it
      if (csr_wr_en) begin
         first_line_in = csr_wr_data;
         line_in       = csr_wr_data;
      end
   end

   // Mark the last token of the beat
   always_comb begin
      slot_a          = a_raw;
      slot_a.tok.last = !b_raw.valid;
      slot_b          = b_raw;
      slot_b.tok.last = 1'b1;
   end

   // Hold scan state and pending token payload
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         offset_ff     <= 32'd0;
         line_ff       <= FIRST_LINE_RESET;
         first_line_ff <= FIRST_LINE_RESET;
         pend_len_ff   <= 16'd0;
         pend_start_ff <= 32'd0;
      end else begin
         mode_ff       <= mode_in;
         offset_ff     <= offset_in;
         line_ff       <= line_in;
         first_line_ff <= first_line_in;
         pend_len_ff   <= pend_len_in;
         pend_start_ff <= pend_start_in;
      end
   end

   // Hold keyword bytes
   always_ff @(posedge clock) begin
      if (kw_we) begin
         kw_buf_ff[kw_addr] <= item.char_byte;
      end
   end

endmodule

// ===== sv/sts_tok_fifo.sv =====
// ----------------------------------------------------------------------------
// sts_tok_fifo: token queue of the source token scanner
// Takes up to two tokens a cycle from the lexer, in order, and presents the
// oldest one on the result side.
// ----------------------------------------------------------------------------
module sts_tok_fifo
   import sts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  tok_slot_type slot_a,
   input  tok_slot_type slot_b,
   output logic         room,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output token_type    head
);

   token_type            mem_ff [TOK_DEPTH];
   logic [TOK_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [TOK_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [TOK_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TOK_PTR_W-1:0] wr_b;
   logic [TOK_CNT_W-1:0] n_push;
   logic                 pop;

   // Pack the beats so a lone second token lands first
   always_comb begin
      rsp_empty = (cnt_ff == '0);
      room      = (cnt_ff <= TOK_CNT_W'(TOK_DEPTH - 2));
      pop       = rsp_pop && !rsp_empty;
      n_push    = TOK_CNT_W'(slot_a.valid) + TOK_CNT_W'(slot_b.valid);
      wr_b      = wr_ptr_ff + TOK_PTR_W'(slot_a.valid);
      wr_ptr_in = wr_ptr_ff + n_push[TOK_PTR_W-1:0];
      rd_ptr_in = pop ? rd_ptr_ff + TOK_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + n_push - TOK_CNT_W'(pop);
      head      = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store tokens
   always_ff @(posedge clock) begin
      if (slot_a.valid) begin
         mem_ff[wr_ptr_ff] <= slot_a.tok;
      end
      if (slot_b.valid) begin
         mem_ff[wr_b] <= slot_b.tok;
      end
   end

endmodule
